>>> hw/rtl/gea_pkg.sv
// ----------------------------------------------------------------------------
// gea_pkg
// Shared types and constants for the gather-elements address generator.
// ----------------------------------------------------------------------------
package gea_pkg;

    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int IDX_W       = 16;
    localparam int OFS_W       = 32;
    localparam int STRIDE_W    = 32;
    localparam int REG_DIMS    = 4;   // dimensions backed by extent/stride registers
    localparam int RANK_W      = 3;
    localparam int AXIS_W      = 2;
    localparam int AXIS_SIZE_W = 16;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = 2;
    localparam int FIFO_CNT_W  = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TENSOR_RANK   = 3'd0,
        REG_GATHER_AXIS   = 3'd1,
        REG_IN_AXIS_SIZE  = 3'd2,
        REG_OUT_DIMS      = 3'd3,
        REG_IN_STRIDE_LO  = 3'd4,
        REG_IN_STRIDE_HI  = 3'd5,
        REG_OUT_STRIDE_LO = 3'd6,
        REG_OUT_STRIDE_HI = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic index_bad;
        logic last_element;
    } t_item_flags;

    localparam int FLAGS_W = $bits(t_item_flags);

endpackage

>>> hw/rtl/gea_fifo.sv
// ----------------------------------------------------------------------------
// gea_fifo
// Small show-ahead queue between the coordinate front end and the offset
// back end.
// ----------------------------------------------------------------------------
module gea_fifo
    import gea_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_not_empty,
    output logic             o_not_full
);

    logic [WIDTH-1:0]      r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [FIFO_CNT_W-1:0] r_count;

    assign o_not_empty = (r_count != '0);
    assign o_not_full  = (r_count != FIFO_CNT_W'(FIFO_DEPTH));
    assign o_rdata     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

>>> hw/rtl/gea_front.sv
// ----------------------------------------------------------------------------
// gea_front
// Output coordinate counter: accepts one index per transaction, range-checks
// it, tags the coordinate with the gather axis and steps the counter in
// row-major order.
// ----------------------------------------------------------------------------
module gea_front
    import gea_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16,
    localparam int ENTRY_W = MAX_RANK*DIM_BITS + IDX_W + MAX_RANK + FLAGS_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic [RANK_W-1:0]      i_tensor_rank,
    input  logic [AXIS_W-1:0]      i_gather_axis,
    input  logic [AXIS_SIZE_W-1:0] i_in_axis_size,
    input  logic [CFG_DATA_W-1:0]  i_out_dims,
    input  logic                   i_in_valid,
    input  logic [IDX_W-1:0]       i_index,
    output logic                   o_in_ready,
    input  logic                   i_q_ready,
    output logic                   o_q_push,
    output logic [ENTRY_W-1:0]     o_q_data
);

    localparam int RK_W = 4;

    logic [MAX_RANK-1:0][DIM_BITS-1:0] r_coord, n_coord;
    logic [MAX_RANK-1:0][DIM_BITS-1:0] ext_m1;
    logic [MAX_RANK-1:0][DIM_BITS-1:0] coord_used;
    logic [MAX_RANK-1:0]               in_use, at_end, hit, carry;
    logic [RK_W-1:0]                   rank_raw, rank_eff;
    logic                              accept, last;
    t_item_flags                       flags;

    assign rank_raw = {1'b0, i_tensor_rank};

    always_comb begin
        if (rank_raw == '0) begin
            rank_eff = RK_W'(1);
        end else if (rank_raw > RK_W'(MAX_RANK)) begin
            rank_eff = RK_W'(MAX_RANK);
        end else begin
            rank_eff = rank_raw;
        end
    end

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_dim
        // zero extent behaves as extent one
        if (d < REG_DIMS && d*DIM_BITS < CFG_DATA_W) begin : g_ext
            logic [DIM_BITS-1:0] ext;
            assign ext       = DIM_BITS'(i_out_dims >> (d*DIM_BITS));
            assign ext_m1[d] = (ext == '0) ? '0 : ext - 1'b1;
        end else begin : g_no_ext
            assign ext_m1[d] = '0;
        end

        if (d < REG_DIMS) begin : g_hit
            assign hit[d] = in_use[d] && (i_gather_axis == AXIS_W'(d));
        end else begin : g_no_hit
            assign hit[d] = 1'b0;
        end

        assign in_use[d]     = (RK_W'(d) < rank_eff);
        assign at_end[d]     = (r_coord[d] >= ext_m1[d]);
        assign coord_used[d] = in_use[d] ? r_coord[d] : '0;
    end

    // carry[d]: every used dimension faster than d sits at its end
    always_comb begin
        carry[MAX_RANK-1] = 1'b1;
        for (int d = MAX_RANK - 2; d >= 0; d--) begin
            carry[d] = carry[d+1] && (!in_use[d+1] || at_end[d+1]);
        end
        last = carry[0] && at_end[0];
    end

    always_comb begin
        for (int d = 0; d < MAX_RANK; d++) begin
            if (last) begin
                n_coord[d] = '0;
            end else if (in_use[d] && carry[d]) begin
                n_coord[d] = at_end[d] ? '0 : r_coord[d] + 1'b1;
            end else begin
                n_coord[d] = r_coord[d];
            end
        end
    end

    assign flags.index_bad    = i_index[IDX_W-1] || (i_index >= i_in_axis_size);
    assign flags.last_element = last;

    assign o_in_ready = i_q_ready;
    assign accept     = i_in_valid && i_q_ready;
    assign o_q_push   = accept;
    assign o_q_data   = {flags, hit, i_index, coord_used};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coord <= '0;
        end else if (accept) begin
            r_coord <= n_coord;
        end
    end

endmodule

>>> hw/rtl/gea_back.sv
// ----------------------------------------------------------------------------
// gea_back
// Offset pipeline: per-dimension stride products, then the two dot-product
// sums into the output register.
// ----------------------------------------------------------------------------
module gea_back
    import gea_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16,
    localparam int ENTRY_W = MAX_RANK*DIM_BITS + IDX_W + MAX_RANK + FLAGS_W
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [REG_DIMS*STRIDE_W-1:0] i_in_strides,
    input  logic [REG_DIMS*STRIDE_W-1:0] i_out_strides,
    input  logic                         i_q_valid,
    input  logic [ENTRY_W-1:0]           i_q_data,
    output logic                         o_q_pop,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [2*OFS_W-1:0]           o_m_tdata,
    output logic                         o_m_tuser,
    output logic                         o_m_tlast
);

    localparam int IDX_LO = MAX_RANK*DIM_BITS;
    localparam int HIT_LO = IDX_LO + IDX_W;
    localparam int FLG_LO = HIT_LO + MAX_RANK;

    logic [MAX_RANK-1:0][DIM_BITS-1:0] q_coord;
    logic [IDX_W-1:0]                  q_index;
    logic [MAX_RANK-1:0]               q_hit;
    t_item_flags                       q_flags;

    logic [MAX_RANK-1:0][OFS_W-1:0]    src_prod, dst_prod;
    logic [MAX_RANK-1:0][OFS_W-1:0]    r_src_prod, r_dst_prod;
    t_item_flags                       r_s1_flags, r_out_flags;
    logic                              r_s1_valid, r_out_valid;
    logic [OFS_W-1:0]                  src_sum, dst_sum, r_src, r_dst;
    logic                              advance;

    assign q_coord = i_q_data[IDX_LO-1:0];
    assign q_index = i_q_data[IDX_LO +: IDX_W];
    assign q_hit   = i_q_data[HIT_LO +: MAX_RANK];
    assign q_flags = t_item_flags'(i_q_data[FLG_LO +: FLAGS_W]);

    for (genvar d = 0; d < MAX_RANK; d++) begin : g_lane
        if (d < REG_DIMS) begin : g_mul
            logic [OFS_W-1:0] src_c, dst_c;
            assign dst_c       = OFS_W'(q_coord[d]);
            assign src_c       = q_hit[d] ? OFS_W'(q_index) : dst_c;
            assign src_prod[d] = src_c * i_in_strides[d*STRIDE_W +: STRIDE_W];
            assign dst_prod[d] = dst_c * i_out_strides[d*STRIDE_W +: STRIDE_W];
        end else begin : g_zero
            assign src_prod[d] = '0;
            assign dst_prod[d] = '0;
        end
    end

    always_comb begin
        src_sum = '0;
        dst_sum = '0;
        for (int d = 0; d < MAX_RANK; d++) begin
            src_sum = src_sum + r_src_prod[d];
            dst_sum = dst_sum + r_dst_prod[d];
        end
    end

    // whole pipe moves when the output register is free or being drained
    assign advance = !r_out_valid || i_m_tready;
    assign o_q_pop = advance && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= i_q_valid;
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_src_prod <= src_prod;
            r_dst_prod <= dst_prod;
            r_s1_flags <= q_flags;
        end
        if (advance && r_s1_valid) begin
            r_src       <= r_s1_flags.index_bad ? '0 : src_sum;
            r_dst       <= dst_sum;
            r_out_flags <= r_s1_flags;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_dst, r_src};
    assign o_m_tuser  = r_out_flags.index_bad;
    assign o_m_tlast  = r_out_flags.last_element;

endmodule

>>> hw/rtl/gather_elements_address_gen_core.sv
// ----------------------------------------------------------------------------
// gather_elements_address_gen_core
// Address generator for a gather-elements kernel.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one signed 16-bit gather index per output element, in
//   row-major output order. m_axis returns one transaction per index:
//   tdata = {dst_offset, src_offset}, tuser = index out of range (src_offset
//   is then zero), tlast = final element of the output tensor, after which
//   the coordinate counter wraps to zero.
//   Registers are written through i_cfg_wr_en / i_cfg_addr / i_cfg_wdata,
//   one per cycle; the user must write them only while no transaction is in
//   flight, which the block itself does not enforce. Throughput: one index
//   per cycle while the queue is not full. An accepted index is written into
//   the queue, then registered in the multiply stage, then summed into the
//   output register.
//   A stall on m_axis freezes the back end; the 4-entry queue keeps
//   s_axis_tready high until it fills.
//   Reset clears the counter, the pipeline and the registers (rank 1, axis
//   size 1, everything else zero).
// ----------------------------------------------------------------------------
module gather_elements_address_gen_core
    import gea_pkg::*;
#(
    parameter int MAX_RANK = 4,
    parameter int DIM_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IDX_W-1:0]      s_axis_tdata,   // [15:0] index_value
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [2*OFS_W-1:0]    m_axis_tdata,   // [31:0] src_offset, [63:32] dst_offset
    output logic                  m_axis_tuser,   // [0] index_bad
    output logic                  m_axis_tlast
);

    localparam int ENTRY_W = MAX_RANK*DIM_BITS + IDX_W + MAX_RANK + FLAGS_W;

    logic [RANK_W-1:0]      r_tensor_rank;
    logic [AXIS_W-1:0]      r_gather_axis;
    logic [AXIS_SIZE_W-1:0] r_in_axis_size;
    logic [CFG_DATA_W-1:0]  r_out_dims;
    logic [CFG_DATA_W-1:0]  r_in_stride_lo, r_in_stride_hi;
    logic [CFG_DATA_W-1:0]  r_out_stride_lo, r_out_stride_hi;

    logic                   q_push, q_pop, q_not_empty, q_not_full;
    logic [ENTRY_W-1:0]     q_wdata, q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tensor_rank   <= RANK_W'(1);
            r_gather_axis   <= '0;
            r_in_axis_size  <= AXIS_SIZE_W'(1);
            r_out_dims      <= '0;
            r_in_stride_lo  <= '0;
            r_in_stride_hi  <= '0;
            r_out_stride_lo <= '0;
            r_out_stride_hi <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_TENSOR_RANK:   r_tensor_rank   <= i_cfg_wdata[RANK_W-1:0];
                REG_GATHER_AXIS:   r_gather_axis   <= i_cfg_wdata[AXIS_W-1:0];
                REG_IN_AXIS_SIZE:  r_in_axis_size  <= i_cfg_wdata[AXIS_SIZE_W-1:0];
                REG_OUT_DIMS:      r_out_dims      <= i_cfg_wdata;
                REG_IN_STRIDE_LO:  r_in_stride_lo  <= i_cfg_wdata;
                REG_IN_STRIDE_HI:  r_in_stride_hi  <= i_cfg_wdata;
                REG_OUT_STRIDE_LO: r_out_stride_lo <= i_cfg_wdata;
                REG_OUT_STRIDE_HI: r_out_stride_hi <= i_cfg_wdata;
                default:           r_tensor_rank   <= r_tensor_rank;
            endcase
        end
    end

    gea_front #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tensor_rank  (r_tensor_rank),
        .i_gather_axis  (r_gather_axis),
        .i_in_axis_size (r_in_axis_size),
        .i_out_dims     (r_out_dims),
        .i_in_valid     (s_axis_tvalid),
        .i_index        (s_axis_tdata),
        .o_in_ready     (s_axis_tready),
        .i_q_ready      (q_not_full),
        .o_q_push       (q_push),
        .o_q_data       (q_wdata)
    );

    gea_fifo #(
        .WIDTH (ENTRY_W)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_wdata     (q_wdata),
        .i_pop       (q_pop),
        .o_rdata     (q_rdata),
        .o_not_empty (q_not_empty),
        .o_not_full  (q_not_full)
    );

    gea_back #(
        .MAX_RANK (MAX_RANK),
        .DIM_BITS (DIM_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_strides  ({r_in_stride_hi, r_in_stride_lo}),
        .i_out_strides ({r_out_stride_hi, r_out_stride_lo}),
        .i_q_valid     (q_not_empty),
        .i_q_data      (q_rdata),
        .o_q_pop       (q_pop),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser),
        .o_m_tlast     (m_axis_tlast)
    );

endmodule

>>> hw/rtl/gea_checker.sv
// ----------------------------------------------------------------------------
// gea_checker
// Port-level checks for the gather-elements address generator.
// ----------------------------------------------------------------------------
module gea_checker
    import gea_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [2*OFS_W-1:0] m_axis_tdata,
    input logic               m_axis_tuser,
    input logic               m_axis_tlast
);

    // pipeline empties on reset
    a_reset_no_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // queue is empty after reset, so input side must be open
    a_reset_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

    // out-of-range index forces the source offset to zero
    a_bad_src_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[OFS_W-1:0] == '0))
        else $error("flagged index with nonzero src offset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("output transaction changed while stalled");

endmodule

bind gather_elements_address_gen_core gea_checker u_gea_checker (.*);
